>>> rtl/phase_arc_slip_tracker_defines.svh
// Assertion macros of the phase arc slip tracker RTL.
`ifndef PHASE_ARC_SLIP_TRACKER_DEFINES_SVH
`define PHASE_ARC_SLIP_TRACKER_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define PATS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PATS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pats_pkg.sv
// Types and constants of the phase arc slip tracker.
`default_nettype none
package pats_pkg;

	localparam int TIME_W     = 63;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVELENGTH_ONE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVELENGTH_TWO  = 3'd5;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_FLUSH   = 1'b1;

	localparam logic KIND_CLOSE = 1'b0;
	localparam logic KIND_MARK  = 1'b1;

	localparam logic [2:0] REASON_START      = 3'd0;
	localparam logic [2:0] REASON_TIMEOUT    = 3'd1;
	localparam logic [2:0] REASON_LOCK       = 3'd2;
	localparam logic [2:0] REASON_HALF       = 3'd3;
	localparam logic [2:0] REASON_JUMP       = 3'd4;
	localparam logic [2:0] REASON_STREAM_END = 3'd5;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [23:0] MARK_MAX   = 24'hFFFFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SUM,
		ST_ROUND,
		ST_DIFF,
		ST_JMUL,
		ST_DECIDE,
		ST_EMIT_CLOSE,
		ST_EMIT_MARK,
		ST_FL_SCAN,
		ST_FL_OUT
	} state_t;

	typedef struct packed {
		logic [31:0]       ident;
		logic [TIME_W-1:0] start_t;
		logic [TIME_W-1:0] last_t;
		logic              emit_valid;
		logic [TIME_W-1:0] emit_t;
		logic [23:0]       marks;
		logic [2:0]        open_reason;
		logic [31:0]       gf;
		logic [31:0]       lock_one;
		logic [31:0]       lock_two;
		logic [1:0]        subhalf;
	} arc_entry_t;

	typedef struct packed {
		logic              kind;
		logic [4:0]        sat_out;
		logic [31:0]       arc_id;
		logic [2:0]        start_reason;
		logic [2:0]        end_reason;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [31:0]       geometry_free;
		logic [23:0]       mark_count;
		logic              last;
	} rec_t;

endpackage
`default_nettype wire

>>> rtl/pats_if.sv
// Observation and result stream interfaces of the phase arc slip tracker.
`default_nettype none
interface pats_obs_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [62:0]        time_ns;
	logic [4:0]         sat_number;
	logic signed [47:0] phase_one;
	logic signed [47:0] phase_two;
	logic signed [31:0] lock_time_one;
	logic signed [31:0] lock_time_two;
	logic               subhalf_one;
	logic               subhalf_two;
	logic               half_pending;
	logic               phases_valid;

	modport source (
		output valid, opcode, time_ns, sat_number, phase_one, phase_two,
		output lock_time_one, lock_time_two, subhalf_one, subhalf_two,
		output half_pending, phases_valid,
		input  ready
	);
	modport sink (
		input  valid, opcode, time_ns, sat_number, phase_one, phase_two,
		input  lock_time_one, lock_time_two, subhalf_one, subhalf_two,
		input  half_pending, phases_valid,
		output ready
	);
endinterface

interface pats_res_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [4:0]         sat_out;
	logic [31:0]        arc_id;
	logic [2:0]         start_reason;
	logic [2:0]         end_reason;
	logic [62:0]        start_time;
	logic [62:0]        end_time;
	logic signed [31:0] geometry_free;
	logic [23:0]        mark_count;
	logic               last;

	modport source (
		output valid, kind, sat_out, arc_id, start_reason, end_reason,
		output start_time, end_time, geometry_free, mark_count, last,
		input  ready
	);
	modport sink (
		input  valid, kind, sat_out, arc_id, start_reason, end_reason,
		input  start_time, end_time, geometry_free, mark_count, last,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/phase_arc_slip_tracker.sv
// Phase arc slip tracker: per-satellite arc table with geometry-free slip detection.
`default_nettype none
// One arc record per satellite lives in a single synchronous table whose read data
// is registered. An observation beat is taken only when the block is idle: a valid
// in-range observation passes the states LOAD, SUM, ROUND, DIFF, JMUL and DECIDE,
// reading the table, forming the geometry-free value through four 23x24 partial
// products and evaluating the jump limit, then spends one cycle per result beat
// (close record and/or sample mark) once the output register is free. A half-cycle
// observation passes LOAD and, when an arc is open, EMIT_CLOSE; a dropped observation
// is taken in IDLE and goes no further. A flush walks the table one entry per cycle,
// stopping at each open arc until the output register is free for its close record.
// The output register lets the next observation be taken while the last result beat still waits.
module phase_arc_slip_tracker #(
	parameter int NUM_SATS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [pats_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pats_pkg::CFG_DATA_W-1:0]  cfg_data,
	pats_obs_if.sink                              obs,
	pats_res_if.source                            res
);
	import pats_pkg::*;

	`include "phase_arc_slip_tracker_defines.svh"

	localparam int IDX_W = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SATS - 1);

	state_t state_q, state_d;

	logic [39:0] gap_q, interval_q;
	logic [19:0] jump_q, rate_q;
	logic [22:0] wl1_q, wl2_q;

	logic [NUM_SATS-1:0] arc_open_q;
	logic [31:0]         next_ident_q;
	logic [IDX_W-1:0]    scan_q;
	logic                have_mark_q;
	logic                res_valid_q;
	rec_t                res_q, res_d;
	logic                res_load;

	arc_entry_t arc_mem [NUM_SATS];
	arc_entry_t rd_q;
	logic [IDX_W-1:0] rd_addr;

	logic [TIME_W-1:0]  t_q;
	logic [IDX_W-1:0]   sat_idx_q;
	logic signed [47:0] p1_q, p2_q;
	logic [31:0]        lk1_q, lk2_q;
	logic [1:0]         sub_q;
	logic               half_q;

	logic [TIME_W-1:0]  el_s1;
	logic               timeout_s1, lock_s1, sub_s1, since_ok_s1;
	logic signed [47:0] pp1hi_s1, pp2hi_s1;
	logic [46:0]        pp1lo_s1, pp2lo_s1;
	logic signed [72:0] x_s2;
	logic [39:0]        rlhi_s2, rllo_s2;
	logic [49:0]        jlns_s2;
	logic [31:0]        gf_s3;
	logic [63:0]        rhs_s3;
	logic [32:0]        ad_s4;
	logic [62:0]        lhs_s5;

	rec_t close_rec_q, mark_rec_q;

	logic               out_free, obs_take, start_obs, in_range, cur_open;
	logic [TIME_W-1:0]  el_c, since_c;
	logic signed [47:0] pp1hi_c, pp2hi_c;
	logic [46:0]        pp1lo_c, pp2lo_c;
	logic signed [72:0] prod1_c, prod2_c, xr_c;
	logic [42:0]        q_c;
	logic [31:0]        gf_c;
	logic [39:0]        rlhi_c, rllo_c;
	logic [49:0]        jlns_c;
	logic [63:0]        rhs_c;
	logic [32:0]        d_c, ad_c;
	logic [62:0]        lhs_c;
	logic               lock1_c, lock2_c;

	logic [2:0]         reason_c;
	logic               new_arc_c, mark_c, jump_c;
	arc_entry_t         new_entry_c;
	rec_t               close_c, mark_rec_c, flush_rec_c, half_rec_c;
	logic [NUM_SATS-1:0] open_rest_c;
	logic               mem_we;

	function automatic rec_t make_rec(input arc_entry_t e, input logic [IDX_W-1:0] idx,
			input logic kind, input logic [2:0] end_reason,
			input logic [TIME_W-1:0] end_t, input logic last);
		rec_t r;
		r.kind          = kind;
		r.sat_out       = 5'(idx);
		r.arc_id        = e.ident;
		r.start_reason  = e.open_reason;
		r.end_reason    = end_reason;
		r.start_time    = e.start_t;
		r.end_time      = end_t;
		r.geometry_free = e.gf;
		r.mark_count    = e.marks;
		r.last          = last;
		return r;
	endfunction

	assign out_free  = !res_valid_q || res.ready;
	assign obs.ready = (state_q == ST_IDLE);
	assign obs_take  = obs.valid && obs.ready;
	assign in_range  = ({2'b00, obs.sat_number} < 7'(NUM_SATS));
	assign start_obs = obs_take && (obs.opcode == OP_OBSERVE) && obs.phases_valid && in_range;
	assign cur_open  = arc_open_q[sat_idx_q];

	always_comb begin
		case (state_q)
			ST_IDLE:                rd_addr = IDX_W'(obs.sat_number);
			ST_FL_SCAN, ST_FL_OUT:  rd_addr = scan_q;
			default:                rd_addr = sat_idx_q;
		endcase
	end

	// datapath, one step per cycle from the latched beat and table read
	always_comb begin
		el_c    = (t_q >= rd_q.last_t) ? t_q - rd_q.last_t : '0;
		since_c = (t_q >= rd_q.emit_t) ? t_q - rd_q.emit_t : '0;
		lock1_c = !lk1_q[31] && !rd_q.lock_one[31] && ($signed(lk1_q) < $signed(rd_q.lock_one));
		lock2_c = !lk2_q[31] && !rd_q.lock_two[31] && ($signed(lk2_q) < $signed(rd_q.lock_two));
		pp1hi_c = $signed({1'b0, wl1_q}) * $signed(p1_q[47:24]);
		pp2hi_c = $signed({1'b0, wl2_q}) * $signed(p2_q[47:24]);
		pp1lo_c = wl1_q * p1_q[23:0];
		pp2lo_c = wl2_q * p2_q[23:0];

		prod1_c = $signed({pp1hi_s1[47], pp1hi_s1, 24'b0}) + $signed({26'b0, pp1lo_s1});
		prod2_c = $signed({pp2hi_s1[47], pp2hi_s1, 24'b0}) + $signed({26'b0, pp2lo_s1});
		rlhi_c  = rate_q * el_s1[39:20];
		rllo_c  = rate_q * el_s1[19:0];
		jlns_c  = jump_q * NS_PER_SEC;

		xr_c = x_s2 + 73'sd536870912;
		q_c  = xr_c[72:30];
		if (!q_c[42] && (|q_c[41:31]))
			gf_c = 32'h7FFFFFFF;
		else if (q_c[42] && !(&q_c[41:31]))
			gf_c = 32'h80000000;
		else
			gf_c = q_c[31:0];
		rhs_c = {4'b0, rlhi_s2, 20'b0} + {24'b0, rllo_s2} + {14'b0, jlns_s2};

		d_c  = {gf_s3[31], gf_s3} - {rd_q.gf[31], rd_q.gf};
		ad_c = d_c[32] ? (33'd0 - d_c) : d_c;

		lhs_c = ad_s4 * NS_PER_SEC;
	end

	// decision on the table entry
	always_comb begin
		jump_c = ({1'b0, lhs_s5} > rhs_s3);
		if (!cur_open)
			reason_c = REASON_START;
		else if (timeout_s1)
			reason_c = REASON_TIMEOUT;
		else if (lock_s1)
			reason_c = REASON_LOCK;
		else if (sub_s1)
			reason_c = REASON_HALF;
		else if (jump_c)
			reason_c = REASON_JUMP;
		else
			reason_c = REASON_START;
		new_arc_c = !cur_open || (reason_c != REASON_START);
		mark_c    = new_arc_c || !rd_q.emit_valid || since_ok_s1;

		new_entry_c          = rd_q;
		new_entry_c.last_t   = t_q;
		new_entry_c.lock_one = lk1_q;
		new_entry_c.lock_two = lk2_q;
		new_entry_c.subhalf  = sub_q;
		new_entry_c.gf       = gf_s3;
		if (new_arc_c) begin
			new_entry_c.ident       = next_ident_q;
			new_entry_c.start_t     = t_q;
			new_entry_c.open_reason = reason_c;
			new_entry_c.marks       = 24'd1;
			new_entry_c.emit_valid  = 1'b1;
			new_entry_c.emit_t      = t_q;
		end else if (mark_c) begin
			new_entry_c.emit_valid = 1'b1;
			new_entry_c.emit_t     = t_q;
			if (rd_q.marks != MARK_MAX)
				new_entry_c.marks = rd_q.marks + 24'd1;
		end

		close_c     = make_rec(rd_q, sat_idx_q, KIND_CLOSE, reason_c, rd_q.last_t, !mark_c);
		mark_rec_c  = make_rec(new_entry_c, sat_idx_q, KIND_MARK, REASON_START, t_q, 1'b1);
		half_rec_c  = make_rec(rd_q, sat_idx_q, KIND_CLOSE, REASON_HALF, rd_q.last_t, 1'b1);
		open_rest_c = arc_open_q;
		open_rest_c[scan_q] = 1'b0;
		flush_rec_c = make_rec(rd_q, scan_q, KIND_CLOSE, REASON_STREAM_END, rd_q.last_t,
			!(|open_rest_c));
	end

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		res_d    = close_rec_q;
		mem_we   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (obs_take && (obs.opcode == OP_FLUSH))
					state_d = ST_FL_SCAN;
				else if (start_obs)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (half_q)
					state_d = cur_open ? ST_EMIT_CLOSE : ST_IDLE;
				else
					state_d = ST_SUM;
			end
			ST_SUM:   state_d = ST_ROUND;
			ST_ROUND: state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_JMUL;
			ST_JMUL:  state_d = ST_DECIDE;
			ST_DECIDE: begin
				mem_we = 1'b1;
				if (cur_open && new_arc_c)
					state_d = ST_EMIT_CLOSE;
				else if (mark_c)
					state_d = ST_EMIT_MARK;
				else
					state_d = ST_IDLE;
			end
			ST_EMIT_CLOSE: begin
				if (out_free) begin
					res_load = 1'b1;
					res_d    = close_rec_q;
					state_d  = have_mark_q ? ST_EMIT_MARK : ST_IDLE;
				end
			end
			ST_EMIT_MARK: begin
				if (out_free) begin
					res_load = 1'b1;
					res_d    = mark_rec_q;
					state_d  = ST_IDLE;
				end
			end
			ST_FL_SCAN: begin
				if (arc_open_q[scan_q])
					state_d = ST_FL_OUT;
				else if (scan_q == LAST_IDX)
					state_d = ST_IDLE;
			end
			ST_FL_OUT: begin
				if (out_free) begin
					res_load = 1'b1;
					res_d    = flush_rec_c;
					state_d  = (scan_q == LAST_IDX) ? ST_IDLE : ST_FL_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gap_q        <= 40'd60000000000;
			interval_q   <= 40'd30000000000;
			jump_q       <= 20'd512;
			rate_q       <= 20'd102;
			wl1_q        <= 23'd3192598;
			wl2_q        <= 23'd4097168;
			arc_open_q   <= '0;
			next_ident_q <= '0;
			scan_q       <= '0;
			have_mark_q  <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_GAP_TIMEOUT:     gap_q      <= cfg_data[39:0];
					CFG_SAMPLE_INTERVAL: interval_q <= cfg_data[39:0];
					CFG_JUMP_LIMIT:      jump_q     <= cfg_data[19:0];
					CFG_RATE_LIMIT:      rate_q     <= cfg_data[19:0];
					CFG_WAVELENGTH_ONE:  wl1_q      <= cfg_data[22:0];
					CFG_WAVELENGTH_TWO:  wl2_q      <= cfg_data[22:0];
					default: ;
				endcase
			end
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
				end
				ST_LOAD: begin
					have_mark_q <= 1'b0;
					if (half_q)
						arc_open_q[sat_idx_q] <= 1'b0;
				end
				ST_DECIDE: begin
					have_mark_q           <= mark_c;
					arc_open_q[sat_idx_q] <= 1'b1;
					if (new_arc_c)
						next_ident_q <= next_ident_q + 32'd1;
				end
				ST_FL_SCAN: begin
					if (!arc_open_q[scan_q] && (scan_q != LAST_IDX))
						scan_q <= scan_q + 1'b1;
				end
				ST_FL_OUT: begin
					if (out_free) begin
						arc_open_q[scan_q] <= 1'b0;
						if (scan_q != LAST_IDX)
							scan_q <= scan_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			arc_mem[sat_idx_q] <= new_entry_c;
		rd_q <= arc_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (obs_take) begin
			t_q       <= obs.time_ns;
			sat_idx_q <= IDX_W'(obs.sat_number);
			p1_q      <= obs.phase_one;
			p2_q      <= obs.phase_two;
			lk1_q     <= obs.lock_time_one;
			lk2_q     <= obs.lock_time_two;
			sub_q     <= {obs.subhalf_two, obs.subhalf_one};
			half_q    <= obs.half_pending;
		end
		el_s1       <= el_c;
		timeout_s1  <= (el_c > {23'b0, gap_q});
		lock_s1     <= lock1_c || lock2_c;
		sub_s1      <= (sub_q != rd_q.subhalf);
		since_ok_s1 <= !(since_c < {23'b0, interval_q});
		pp1hi_s1    <= pp1hi_c;
		pp2hi_s1    <= pp2hi_c;
		pp1lo_s1    <= pp1lo_c;
		pp2lo_s1    <= pp2lo_c;
		x_s2        <= prod1_c - prod2_c;
		rlhi_s2     <= rlhi_c;
		rllo_s2     <= rllo_c;
		jlns_s2     <= jlns_c;
		gf_s3       <= gf_c;
		rhs_s3      <= rhs_c;
		ad_s4       <= ad_c;
		lhs_s5      <= lhs_c;
		if (state_q == ST_DECIDE) begin
			close_rec_q <= close_c;
			mark_rec_q  <= mark_rec_c;
		end else if (state_q == ST_LOAD) begin
			close_rec_q <= half_rec_c;
		end
		if (res_load)
			res_q <= res_d;
	end

	assign res.valid         = res_valid_q;
	assign res.kind          = res_q.kind;
	assign res.sat_out       = res_q.sat_out;
	assign res.arc_id        = res_q.arc_id;
	assign res.start_reason  = res_q.start_reason;
	assign res.end_reason    = res_q.end_reason;
	assign res.start_time    = res_q.start_time;
	assign res.end_time      = res_q.end_time;
	assign res.geometry_free = $signed(res_q.geometry_free);
	assign res.mark_count    = res_q.mark_count;
	assign res.last          = res_q.last;

	`PATS_ASSERT(a_one_obs_at_a_time, start_obs |=> !obs.ready, "beat taken during observation")
	`PATS_ASSERT(a_write_opens_arc, mem_we |=> arc_open_q[sat_idx_q], "table write left arc closed")
	`PATS_ASSERT(a_mark_counted, (res.valid && (res.kind == KIND_MARK)) |-> (res.mark_count != 24'd0), "mark beat with zero count")
	`PATS_ASSERT(a_close_has_reason, (res.valid && (res.kind == KIND_CLOSE)) |-> (res.end_reason != REASON_START), "close beat without end reason")
	`PATS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !res.valid, "result valid during reset")

endmodule
`default_nettype wire

>>> test/pats_checker.sv
// Result checker of the phase arc slip tracker: watches the beats, predicts and compares.
module pats_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [pats_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pats_pkg::CFG_DATA_W-1:0]    cfg_data,
	pats_obs_if                                obs,
	pats_res_if                                res,
	output int                                 errors,
	output int                                 pending
);
	import pats_pkg::*;

	logic [39:0] gap_to, samp_iv;
	logic [19:0] jlim, rlim;
	logic [22:0] wl_one, wl_two;

	logic               open_q [32];
	logic [31:0]        ident_q [32];
	logic [62:0]        start_q [32];
	logic [62:0]        last_q [32];
	logic               emv_q [32];
	logic [62:0]        emt_q [32];
	logic [23:0]        marks_q [32];
	logic [2:0]         why_q [32];
	logic signed [31:0] gf_q [32];
	logic signed [31:0] lk1_q [32];
	logic signed [31:0] lk2_q [32];
	logic [1:0]         sub_q [32];
	logic [31:0]        next_id;

	rec_t expected_recs [$];
	int   n_new;

	function automatic rec_t arc_record(int s, logic k, logic [2:0] er, logic [62:0] et);
		rec_t r;
		r.kind = k;
		r.sat_out = s[4:0];
		r.arc_id = ident_q[s];
		r.start_reason = why_q[s];
		r.end_reason = er;
		r.start_time = start_q[s];
		r.end_time = et;
		r.geometry_free = gf_q[s];
		r.mark_count = marks_q[s];
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic signed [31:0] geo_free(logic signed [47:0] p1,
			logic signed [47:0] p2);
		logic signed [79:0] a, b, w1, w2, prod, q;
		a = p1;
		b = p2;
		w1 = {57'b0, wl_one};
		w2 = {57'b0, wl_two};
		prod = a * w1 - b * w2 + (80'sd1 <<< 29);
		q = prod >>> 30;
		if (q > 80'sd2147483647) return 32'sh7FFFFFFF;
		if (q < -80'sd2147483648) return 32'sh80000000;
		return q[31:0];
	endfunction

	task automatic close_arc(int s, logic [2:0] er);
		if (open_q[s]) begin
			expected_recs.insert(expected_recs.size(), arc_record(s, KIND_CLOSE, er, last_q[s]));
			open_q[s] = 1'b0;
			n_new++;
		end
	endtask

	task automatic predict_obs();
		logic [62:0]        t, el, since;
		logic signed [31:0] gf, l1, l2, o1, o2;
		logic signed [33:0] d;
		logic [33:0]        ad;
		logic [1:0]         sub;
		logic [2:0]         why;
		logic [127:0]       lhs, rhs;
		int                 s;
		t = obs.time_ns;
		s = int'(obs.sat_number);
		n_new = 0;
		if (obs.opcode == OP_FLUSH) begin
			for (int i = 0; i < 32; i++) close_arc(i, REASON_STREAM_END);
		end else if (obs.phases_valid) begin
			if (obs.half_pending) begin
				close_arc(s, REASON_HALF);
			end else begin
				gf = geo_free(obs.phase_one, obs.phase_two);
				l1 = obs.lock_time_one;
				l2 = obs.lock_time_two;
				sub = {obs.subhalf_two, obs.subhalf_one};
				why = REASON_START;
				if (open_q[s]) begin
					el = (t >= last_q[s]) ? t - last_q[s] : 63'd0;
					o1 = lk1_q[s];
					o2 = lk2_q[s];
					d = 34'(gf) - 34'(gf_q[s]);
					ad = (d < 0) ? -d : d;
					lhs = 128'(ad) * 128'd1000000000;
					rhs = 128'(jlim) * 128'd1000000000 + 128'(rlim) * 128'(el);
					if (64'(el) > 64'(gap_to)) why = REASON_TIMEOUT;
					else if ((l1 >= 0 && o1 >= 0 && l1 < o1) ||
							(l2 >= 0 && o2 >= 0 && l2 < o2)) why = REASON_LOCK;
					else if (sub != sub_q[s]) why = REASON_HALF;
					else if (lhs > rhs) why = REASON_JUMP;
					if (why != REASON_START) close_arc(s, why);
				end
				if (!open_q[s]) begin
					open_q[s] = 1'b1;
					ident_q[s] = next_id;
					next_id++;
					start_q[s] = t;
					why_q[s] = why;
					emv_q[s] = 1'b0;
					marks_q[s] = '0;
				end
				last_q[s] = t;
				lk1_q[s] = l1;
				lk2_q[s] = l2;
				sub_q[s] = sub;
				gf_q[s] = gf;
				since = (t >= emt_q[s]) ? t - emt_q[s] : 63'd0;
				if (!emv_q[s] || 64'(since) >= 64'(samp_iv)) begin
					emv_q[s] = 1'b1;
					emt_q[s] = t;
					if (marks_q[s] != MARK_MAX) marks_q[s]++;
					expected_recs.insert(expected_recs.size(),
						arc_record(s, KIND_MARK, REASON_START, t));
					n_new++;
				end
			end
		end
		if (n_new > 0) expected_recs[expected_recs.size()-1].last = 1'b1;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task automatic check_beat();
		rec_t w;
		if (expected_recs.size() == 0) begin
			report("unexpected beat", {32'b0, res.arc_id}, 64'd0);
			return;
		end
		w = expected_recs.pop_front();
		if (res.kind !== w.kind) report("kind", 64'(res.kind), 64'(w.kind));
		if (res.sat_out !== w.sat_out) report("sat_out", 64'(res.sat_out), 64'(w.sat_out));
		if (res.arc_id !== w.arc_id) report("arc_id", 64'(res.arc_id), 64'(w.arc_id));
		if (res.start_reason !== w.start_reason)
			report("start_reason", 64'(res.start_reason), 64'(w.start_reason));
		if (res.end_reason !== w.end_reason)
			report("end_reason", 64'(res.end_reason), 64'(w.end_reason));
		if (res.start_time !== w.start_time)
			report("start_time", 64'(res.start_time), 64'(w.start_time));
		if (res.end_time !== w.end_time)
			report("end_time", 64'(res.end_time), 64'(w.end_time));
		if (res.geometry_free !== w.geometry_free)
			report("geometry_free", 64'(res.geometry_free), 64'(w.geometry_free));
		if (res.mark_count !== w.mark_count)
			report("mark_count", 64'(res.mark_count), 64'(w.mark_count));
		if (res.last !== w.last) report("last", 64'(res.last), 64'(w.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_to <= 40'd60000000000;
			samp_iv <= 40'd30000000000;
			jlim <= 20'd512;
			rlim <= 20'd102;
			wl_one <= 23'd3192598;
			wl_two <= 23'd4097168;
			for (int i = 0; i < 32; i++) begin
				open_q[i] = 1'b0;
				emt_q[i] = '0;
			end
			next_id = '0;
			errors = 0;
			pending = 0;
		end else begin
			if (res.valid && res.ready) check_beat();
			if (obs.valid && obs.ready) predict_obs();
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_GAP_TIMEOUT: gap_to <= cfg_data;
					CFG_SAMPLE_INTERVAL: samp_iv <= cfg_data;
					CFG_JUMP_LIMIT: jlim <= cfg_data[19:0];
					CFG_RATE_LIMIT: rlim <= cfg_data[19:0];
					CFG_WAVELENGTH_ONE: wl_one <= cfg_data[22:0];
					CFG_WAVELENGTH_TWO: wl_two <= cfg_data[22:0];
					default: ;
				endcase
			end
			pending = expected_recs.size();
		end
	end
endmodule

>>> test/tb_top.sv
// Testbench top of the phase arc slip tracker: clock, reset, stimulus and verdict.
module tb_top;
	import pats_pkg::*;

	localparam int WATCH_LIMIT = 5000;
	localparam int SETTLE = 120;

	logic                  clk, arst_n, cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors, pending, quiet;
	bit                    no_idle;
	int                    rd_stall;

	logic [62:0]        cur_t;
	logic [39:0]        cur_gap;
	logic signed [47:0] bp1 [32];
	logic signed [47:0] bp2 [32];
	logic signed [31:0] blk [32];
	logic [1:0]         bsub [32];

	pats_obs_if obs_if();
	pats_res_if res_if();

	phase_arc_slip_tracker dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .obs(obs_if), .res(res_if)
	);

	pats_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .obs(obs_if), .res(res_if), .errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		if (no_idle) begin
			res_if.ready <= 1'b1;
		end else if (rd_stall > 0) begin
			res_if.ready <= 1'b0;
			rd_stall <= rd_stall - 1;
		end else if ($urandom_range(99) < 20) begin
			res_if.ready <= 1'b0;
			rd_stall <= $urandom_range(2);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((obs_if.valid && obs_if.ready) || (res_if.valid && res_if.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("phase_arc_slip_tracker test failed");
			$finish;
		end
	end

	task automatic send(logic op, logic [62:0] t, logic [4:0] s, logic [47:0] p1,
			logic [47:0] p2, logic [31:0] l1, logic [31:0] l2, logic s1, logic s2,
			logic h, logic v);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 25) begin
			gap = $urandom_range(1, 3);
			obs_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		obs_if.opcode = op;
		obs_if.time_ns = t;
		obs_if.sat_number = s;
		obs_if.phase_one = p1;
		obs_if.phase_two = p2;
		obs_if.lock_time_one = l1;
		obs_if.lock_time_two = l2;
		obs_if.subhalf_one = s1;
		obs_if.subhalf_two = s2;
		obs_if.half_pending = h;
		obs_if.phases_valid = v;
		obs_if.valid = 1'b1;
		do @(posedge clk); while (!obs_if.ready);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == CFG_GAP_TIMEOUT) cur_gap = val;
	endtask

	task automatic drain();
		@(negedge clk);
		obs_if.valid = 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_all(logic [39:0] g, logic [39:0] iv, logic [19:0] j,
			logic [19:0] r, logic [22:0] w1, logic [22:0] w2);
		write_reg(CFG_GAP_TIMEOUT, g);
		write_reg(CFG_SAMPLE_INTERVAL, iv);
		write_reg(CFG_JUMP_LIMIT, 40'(j));
		write_reg(CFG_RATE_LIMIT, 40'(r));
		write_reg(CFG_WAVELENGTH_ONE, 40'(w1));
		write_reg(CFG_WAVELENGTH_TWO, 40'(w2));
	endtask

	task automatic random_item();
		int          r, s;
		logic [63:0] step;
		r = $urandom_range(99);
		s = $urandom_range(31);
		if (r < 4) begin
			send(OP_FLUSH, cur_t, 5'(s), 48'($urandom), 48'($urandom), $urandom,
				$urandom, 1'b0, 1'b0, 1'b0, 1'b1);
			return;
		end
		r = $urandom_range(99);
		if (r < 8) step = '0;
		else if (r < 14) step = (cur_t > 63'd5000) ? -64'($urandom_range(1, 5000)) : '0;
		else if (r < 22) step = 64'(cur_gap) + 64'($urandom_range(1, 1000));
		else step = ({$urandom, $urandom} % 64'(cur_gap)) + 64'd1;
		cur_t = cur_t + step[62:0];
		r = $urandom_range(99);
		if (r < 8) begin
			bp1[s] = 48'({$urandom, $urandom});
			bp2[s] = 48'({$urandom, $urandom});
		end else begin
			bp1[s] = bp1[s] + 48'($urandom_range(8191)) - 48'sd4096;
			bp2[s] = bp2[s] + 48'($urandom_range(8191)) - 48'sd4096;
		end
		r = $urandom_range(99);
		if (r < 5) blk[s] = -32'sd1;
		else if (r < 10) blk[s] = $urandom_range(1000);
		else if (r < 14) blk[s] = 32'($urandom >> 1);
		else if (blk[s] >= 0 && blk[s] < 32'sh7FF00000) blk[s] = blk[s] + $urandom_range(5000);
		if ($urandom_range(99) < 6) bsub[s] = 2'($urandom);
		send(OP_OBSERVE, cur_t, 5'(s), bp1[s], bp2[s], blk[s],
			($urandom_range(99) < 5) ? -32'sd1 : blk[s], bsub[s][0], bsub[s][1],
			$urandom_range(99) < 5, $urandom_range(99) < 95);
	endtask

	task automatic random_phase(int count);
		cur_t = 63'({$urandom, $urandom} >> 3);
		for (int i = 0; i < 32; i++) begin
			bp1[i] = 48'({$urandom, $urandom});
			bp2[i] = 48'({$urandom, $urandom});
			blk[i] = $urandom_range(100000);
			bsub[i] = 2'($urandom);
		end
		for (int i = 0; i < count; i++) random_item();
		send(OP_FLUSH, cur_t, 5'd0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		obs_if.valid = 1'b0;
		obs_if.opcode = OP_OBSERVE;
		obs_if.time_ns = '0;
		obs_if.sat_number = '0;
		obs_if.phase_one = '0;
		obs_if.phase_two = '0;
		obs_if.lock_time_one = '0;
		obs_if.lock_time_two = '0;
		obs_if.subhalf_one = 1'b0;
		obs_if.subhalf_two = 1'b0;
		obs_if.half_pending = 1'b0;
		obs_if.phases_valid = 1'b0;
		no_idle = 1'b0;
		cur_gap = 40'd60000000000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: opens, repeats, backward time, each slip cause, flushes, extremes
		send(OP_FLUSH, 63'd0, 5'd0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd1000, 5'd0, 48'd100000, 48'd70000, 32'd10, 32'd10,
			1'b0, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd1000, 5'd0, 48'd100000, 48'd70000, 32'd10, 32'd10,
			1'b0, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd500, 5'd0, 48'd100010, 48'd70010, 32'd20, 32'd20,
			1'b0, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd40000000000, 5'd0, 48'd100020, 48'd70020, 32'd5, 32'd30,
			1'b0, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd41000000000, 5'd0, 48'd100020, 48'd70020, 32'd50, 32'd3,
			1'b0, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd42000000000, 5'd0, 48'd100020, 48'd70020, 32'd60, 32'd60,
			1'b1, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd43000000000, 5'd0, 48'd900000000, 48'd70020, 32'd70,
			32'd70, 1'b1, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd200000000000, 5'd0, 48'd900000000, 48'd70020, -32'sd1,
			-32'sd1, 1'b1, 1'b0, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd200000000001, 5'd0, 48'd5, 48'd5, 32'd1, 32'd1,
			1'b1, 1'b0, 1'b0, 1'b0);
		send(OP_OBSERVE, 63'd200000000002, 5'd0, 48'd5, 48'd5, 32'd1, 32'd1,
			1'b1, 1'b1, 1'b1, 1'b1);
		send(OP_OBSERVE, 63'd200000000003, 5'd0, 48'd5, 48'd5, 32'd1, 32'd1,
			1'b1, 1'b1, 1'b1, 1'b1);
		send(OP_OBSERVE, 63'h7FFFFFFFFFFFFFFF, 5'd31, 48'h7FFFFFFFFFFF,
			48'h800000000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b1, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'h7FFFFFFFFFFFFFFF, 5'd30, 48'h800000000000,
			48'h7FFFFFFFFFFF, -32'sd1, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1);
		send(OP_OBSERVE, 63'd300000000000, 5'd1, 48'h7FFFFFFFFFFF, 48'h7FFFFFFFFFFF,
			32'd0, -32'sd1, 1'b0, 1'b0, 1'b0, 1'b1);
		send(OP_FLUSH, 63'd0, 5'd0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		send(OP_FLUSH, 63'd0, 5'd0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		drain();

		random_phase(72);
		set_all(40'd1, 40'd1, 20'd1, 20'd0, 23'h7FFFFF, 23'h7FFFFF);
		random_phase(72);
		set_all(40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 20'hFFFFF, 20'hFFFFF, 23'd1, 23'd1);
		random_phase(72);
		set_all(40'd2000000000 + 40'($urandom_range(1000000)), 40'd0,
			20'($urandom_range(1, 4000)), 20'($urandom_range(0, 4000)),
			23'($urandom_range(3000000, 4200000)), 23'($urandom_range(3000000, 4200000)));
		random_phase(72);
		set_all(40'd60000000000, 40'd30000000000, 20'd512, 20'd102,
			23'd3192598, 23'd4097168);
		no_idle = 1'b1;
		random_phase(72);

		if (errors == 0) $display("phase_arc_slip_tracker test passed");
		else $display("phase_arc_slip_tracker test failed");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl
rtl/pats_pkg.sv
rtl/pats_if.sv
rtl/phase_arc_slip_tracker.sv
test/pats_checker.sv
test/tb_top.sv
